// File: sv/quad_outline_hit_classifier_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the quadrilateral hit classifier.
// Each macro builds one labeled concurrent assertion on the rising clock edge,
// disabled while the synchronous reset is held.
// ---------------------------------------------------------------------------
`ifndef QUAD_OUTLINE_HIT_CLASSIFIER_UNIT_ASSERT_SVH
`define QUAD_OUTLINE_HIT_CLASSIFIER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define QOHC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define QOHC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/qohc_pkg.sv
// ---------------------------------------------------------------------------
// qohc_pkg
// Shared constants, codes and types of the quadrilateral hit classifier.
// ---------------------------------------------------------------------------
package qohc_pkg;

  // Port and register widths.
  localparam int PORT_COORD_W = 16;
  localparam int CFG_W        = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int HIT_W        = 4;
  localparam int RADIUS_W     = 8;

  // Parameter defaults.
  localparam int COORD_BITS_DEF = 16;
  localparam int TOL_RECIP_DEF  = 1000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TR     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BL     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd5;

  // Mode bits and reset values.
  localparam int MODE_EDGE   = 0;
  localparam int MODE_VERTEX = 1;
  localparam logic [1:0]          MODE_RST   = 2'd1;
  localparam logic [RADIUS_W-1:0] RADIUS_RST = 8'd4;

  // Corner slots in the corner array.
  localparam int C_TL = 0;
  localparam int C_TR = 1;
  localparam int C_BR = 2;
  localparam int C_BL = 3;

  // Result codes.
  localparam logic [HIT_W-1:0] HIT_NONE   = 4'd0;
  localparam logic [HIT_W-1:0] HIT_TL     = 4'd1;
  localparam logic [HIT_W-1:0] HIT_TR     = 4'd2;
  localparam logic [HIT_W-1:0] HIT_BR     = 4'd3;
  localparam logic [HIT_W-1:0] HIT_BL     = 4'd4;
  localparam logic [HIT_W-1:0] HIT_TOP    = 4'd5;
  localparam logic [HIT_W-1:0] HIT_RIGHT  = 4'd6;
  localparam logic [HIT_W-1:0] HIT_BOTTOM = 4'd7;
  localparam logic [HIT_W-1:0] HIT_LEFT   = 4'd8;
  localparam logic [HIT_W-1:0] HIT_WHOLE  = 4'd9;

  // Segment slots in the segment result vector.
  localparam int SEG_LEFT   = 0;
  localparam int SEG_TOP    = 1;
  localparam int SEG_RIGHT  = 2;
  localparam int SEG_BOTTOM = 3;
  localparam int SEG_DIAG   = 4;

  // Early test results that travel down the pipeline with each word.
  typedef struct packed {
    logic       box_a;
    logic       box_b;
    logic [3:0] handle;
  } pick_flags_t;

  // Working coordinate width: the low bits of each 16-bit slot.
  function automatic int coord_w(int bits);
    return (bits < PORT_COORD_W) ? bits : PORT_COORD_W;
  endfunction

endpackage

// File: sv/qohc_seg.sv
// ---------------------------------------------------------------------------
// qohc_seg
// Six-stage point-to-segment proximity test. Hit when the point projects
// inside the segment and TOLERANCE_RECIPROCAL * cross^2 < len^2, or, for a
// segment of no length, when the point equals its endpoint.
// ---------------------------------------------------------------------------
module qohc_seg import qohc_pkg::*; #(
  parameter int COORD_BITS           = COORD_BITS_DEF,
  parameter int TOLERANCE_RECIPROCAL = TOL_RECIP_DEF
) (
  input  logic                                   clk,
  input  logic signed [coord_w(COORD_BITS)-1:0]  ax,
  input  logic signed [coord_w(COORD_BITS)-1:0]  ay,
  input  logic signed [coord_w(COORD_BITS)-1:0]  bx,
  input  logic signed [coord_w(COORD_BITS)-1:0]  by,
  input  logic signed [coord_w(COORD_BITS)-1:0]  px,
  input  logic signed [coord_w(COORD_BITS)-1:0]  py,
  output logic                                   hit
);

  localparam int CW  = coord_w(COORD_BITS);
  localparam int DW  = CW + 1;
  localparam int PW  = 2 * DW;
  localparam int SW  = PW + 1;
  localparam int AW  = CW + 1;
  localparam int QW  = 2 * AW;
  localparam int SQW = 2 * CW + 1;
  localparam int H   = (SQW + 1) / 2;
  localparam int HW  = SQW - H;
  localparam int TW  = $clog2(TOLERANCE_RECIPROCAL + 1);
  localparam int PRW = SQW + TW + 1;
  localparam logic [TW-1:0] TOLV = TW'(TOLERANCE_RECIPROCAL);

  // Stage 1: direction and offset vectors.
  logic signed [DW-1:0] dx_r, dy_r, wx_r, wy_r;

  always_ff @(posedge clk) begin
    dx_r <= {bx[CW-1], bx} - {ax[CW-1], ax};
    dy_r <= {by[CW-1], by} - {ay[CW-1], ay};
    wx_r <= {px[CW-1], px} - {ax[CW-1], ax};
    wy_r <= {py[CW-1], py} - {ay[CW-1], ay};
  end

  // Stage 2: the six products.
  logic signed [PW-1:0] xx_r, yy_r, wxdx_r, wydy_r, wxdy_r, wydx_r;
  logic                 wz2_r;

  always_ff @(posedge clk) begin
    xx_r   <= PW'(dx_r) * PW'(dx_r);
    yy_r   <= PW'(dy_r) * PW'(dy_r);
    wxdx_r <= PW'(wx_r) * PW'(dx_r);
    wydy_r <= PW'(wy_r) * PW'(dy_r);
    wxdy_r <= PW'(wx_r) * PW'(dy_r);
    wydx_r <= PW'(wy_r) * PW'(dx_r);
    wz2_r  <= (wx_r == '0) && (wy_r == '0);
  end

  // Stage 3: squared length, projection and cross magnitude.
  logic signed [SW-1:0] len2_r, dot_r, cr_nxt;
  logic        [SW-1:0] ac_r;
  logic                 wz3_r;

  assign cr_nxt = SW'(wxdy_r) - SW'(wydx_r);

  always_ff @(posedge clk) begin
    len2_r <= SW'(xx_r) + SW'(yy_r);
    dot_r  <= SW'(wxdx_r) + SW'(wydy_r);
    ac_r   <= cr_nxt[SW-1] ? SW'(-cr_nxt) : SW'(cr_nxt);
    wz3_r  <= wz2_r;
  end

  // Stage 4: span check and square of the cross magnitude.
  logic            lz4_r, sp4_r, ab4_r, wz4_r;
  logic [QW-1:0]   sq4_r;
  logic [SQW-1:0]  len4_r;

  always_ff @(posedge clk) begin
    lz4_r  <= (len2_r == '0);
    sp4_r  <= (dot_r >= 0) && (dot_r <= len2_r);
    ab4_r  <= |ac_r[SW-1:AW];
    wz4_r  <= wz3_r;
    sq4_r  <= QW'(ac_r[AW-1:0]) * QW'(ac_r[AW-1:0]);
    len4_r <= len2_r[SQW-1:0];
  end

  // Stage 5: scale by the tolerance in two partial products.
  logic               lz5_r, ok5_r, wz5_r;
  logic [HW+TW-1:0]   pph5_r;
  logic [H+TW-1:0]    ppl5_r;
  logic [SQW-1:0]     len5_r;

  always_ff @(posedge clk) begin
    lz5_r  <= lz4_r;
    ok5_r  <= sp4_r && !ab4_r && !sq4_r[QW-1];
    wz5_r  <= wz4_r;
    pph5_r <= (HW+TW)'(sq4_r[SQW-1:H]) * (HW+TW)'(TOLV);
    ppl5_r <= (H+TW)'(sq4_r[H-1:0]) * (H+TW)'(TOLV);
    len5_r <= len4_r;
  end

  // Stage 6: final compare.
  logic [PRW-1:0] prod;
  logic           hit_r;

  assign prod = (PRW'(pph5_r) << H) + PRW'(ppl5_r);

  always_ff @(posedge clk) begin
    hit_r <= lz5_r ? wz5_r : (ok5_r && (prod < PRW'(len5_r)));
  end

  assign hit = hit_r;

endmodule

// File: sv/qohc_tri.sv
// ---------------------------------------------------------------------------
// qohc_tri
// Six-stage point-in-triangle test. Barycentric numerators are checked by
// sign against the denominator; a zero denominator gives no hit.
// ---------------------------------------------------------------------------
module qohc_tri import qohc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic signed [coord_w(COORD_BITS)-1:0]  ax,
  input  logic signed [coord_w(COORD_BITS)-1:0]  ay,
  input  logic signed [coord_w(COORD_BITS)-1:0]  bx,
  input  logic signed [coord_w(COORD_BITS)-1:0]  by,
  input  logic signed [coord_w(COORD_BITS)-1:0]  cx,
  input  logic signed [coord_w(COORD_BITS)-1:0]  cy,
  input  logic signed [coord_w(COORD_BITS)-1:0]  px,
  input  logic signed [coord_w(COORD_BITS)-1:0]  py,
  output logic                                   hit
);

  localparam int CW = coord_w(COORD_BITS);
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;
  localparam int XW = SW + 2;

  // True when n/d lies within [0,1]; d is known to be nonzero.
  function automatic logic in_unit(logic signed [XW-1:0] n, logic signed [XW-1:0] d);
    return (d > 0) ? ((n >= 0) && (n <= d)) : ((n <= 0) && (n >= d));
  endfunction

  // Stage 1: edge vectors relative to corner c.
  logic signed [DW-1:0] e1_r, e2_r, e3_r, e4_r, e5_r, qx_r, qy_r;

  always_ff @(posedge clk) begin
    e1_r <= {by[CW-1], by} - {cy[CW-1], cy};
    e2_r <= {cx[CW-1], cx} - {bx[CW-1], bx};
    e3_r <= {ax[CW-1], ax} - {cx[CW-1], cx};
    e4_r <= {ay[CW-1], ay} - {cy[CW-1], cy};
    e5_r <= {cy[CW-1], cy} - {ay[CW-1], ay};
    qx_r <= {px[CW-1], px} - {cx[CW-1], cx};
    qy_r <= {py[CW-1], py} - {cy[CW-1], cy};
  end

  // Stage 2: products.
  logic signed [PW-1:0] m0_r, m1_r, m2_r, m3_r, m4_r, m5_r;

  always_ff @(posedge clk) begin
    m0_r <= PW'(e1_r) * PW'(e3_r);
    m1_r <= PW'(e2_r) * PW'(e4_r);
    m2_r <= PW'(e1_r) * PW'(qx_r);
    m3_r <= PW'(e2_r) * PW'(qy_r);
    m4_r <= PW'(e5_r) * PW'(qx_r);
    m5_r <= PW'(e3_r) * PW'(qy_r);
  end

  // Stage 3: denominator and two numerators.
  logic signed [SW-1:0] den3_r, un3_r, vn3_r;

  always_ff @(posedge clk) begin
    den3_r <= SW'(m0_r) + SW'(m1_r);
    un3_r  <= SW'(m2_r) + SW'(m3_r);
    vn3_r  <= SW'(m4_r) + SW'(m5_r);
  end

  // Stage 4: third numerator.
  logic signed [XW-1:0] den4_r, un4_r, vn4_r, wn4_r;

  always_ff @(posedge clk) begin
    den4_r <= XW'(den3_r);
    un4_r  <= XW'(un3_r);
    vn4_r  <= XW'(vn3_r);
    wn4_r  <= XW'(den3_r) - XW'(un3_r) - XW'(vn3_r);
  end

  // Stage 5: sign checks; stage 6 aligns with the segment unit.
  logic hit5_r, hit6_r;

  always_ff @(posedge clk) begin
    hit5_r <= (den4_r != '0) && in_unit(un4_r, den4_r) && in_unit(vn4_r, den4_r) &&
              in_unit(wn4_r, den4_r);
    hit6_r <= hit5_r;
  end

  assign hit = hit6_r;

endmodule

// File: sv/quad_outline_hit_classifier_unit.sv
// A word accepted on start passes through the seven-stage multiply and compare
// pipeline and has its result strobed on out_valid. Throughput: one word per
// cycle; busy stays low.
// Reset (synchronous, rst_n low) clears the valid pipeline and loads the
// register reset values; words in flight are dropped.
// ---------------------------------------------------------------------------
// quad_outline_hit_classifier_unit
// Classifies a probe point against a configured quadrilateral: corner handles,
// edges, interior or none, with segment and triangle tests in parallel units.
// ---------------------------------------------------------------------------
`include "quad_outline_hit_classifier_unit_assert.svh"

module quad_outline_hit_classifier_unit import qohc_pkg::*; #(
  parameter int COORD_BITS           = COORD_BITS_DEF,
  parameter int TOLERANCE_RECIPROCAL = TOL_RECIP_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [PORT_COORD_W-1:0] in_point_x,
  input  logic [PORT_COORD_W-1:0] in_point_y,
  output logic                    out_valid,
  output logic [HIT_W-1:0]        out_hit_part,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata
);

  localparam int CW = coord_w(COORD_BITS);
  localparam int DW = CW + 1;

  // Configuration registers.
  logic [CFG_W-1:0]    corner_r [4];
  logic [1:0]          mode_r;
  logic [RADIUS_W-1:0] radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_r <= '{default: '0};
      mode_r   <= MODE_RST;
      radius_r <= RADIUS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        REG_TL, REG_TR, REG_BR, REG_BL: corner_r[cfg_index[1:0]] <= cfg_wdata;
        REG_MODE:   mode_r   <= cfg_wdata[1:0];
        REG_RADIUS: radius_r <= cfg_wdata[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  // Corner and point coordinates at the working width.
  logic signed [CW-1:0] cx [4];
  logic signed [CW-1:0] cy [4];
  logic signed [CW-1:0] px, py;

  for (genvar i = 0; i < 4; i++) begin : g_corner
    assign cx[i] = corner_r[i][CW-1:0];
    assign cy[i] = corner_r[i][PORT_COORD_W+CW-1:PORT_COORD_W];
  end

  assign px = in_point_x[CW-1:0];
  assign py = in_point_y[CW-1:0];

  // The pipeline takes a word every cycle.
  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Valid bits travel alongside the data.
  logic [6:1] v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[5:1], accept};
    end
  end

  // Inclusive bounding box of three corners.
  function automatic logic in_box3(logic signed [CW-1:0] ax, logic signed [CW-1:0] ay,
                                   logic signed [CW-1:0] bx, logic signed [CW-1:0] by,
                                   logic signed [CW-1:0] qx, logic signed [CW-1:0] qy,
                                   logic signed [CW-1:0] tx, logic signed [CW-1:0] ty);
    return ((tx >= ax) || (tx >= bx) || (tx >= qx)) &&
           ((tx <= ax) || (tx <= bx) || (tx <= qx)) &&
           ((ty >= ay) || (ty >= by) || (ty >= qy)) &&
           ((ty <= ay) || (ty <= by) || (ty <= qy));
  endfunction

  // Stage 1: bounding boxes and handle offsets.
  logic                 box_a1_r, box_b1_r;
  logic signed [DW-1:0] hex1_r [4];
  logic signed [DW-1:0] hey1_r [4];

  always_ff @(posedge clk) begin
    box_a1_r <= in_box3(cx[C_BL], cy[C_BL], cx[C_TL], cy[C_TL],
                        cx[C_TR], cy[C_TR], px, py);
    box_b1_r <= in_box3(cx[C_BL], cy[C_BL], cx[C_TR], cy[C_TR],
                        cx[C_BR], cy[C_BR], px, py);
    for (int i = 0; i < 4; i++) begin
      hex1_r[i] <= {px[CW-1], px} - {cx[i][CW-1], cx[i]};
      hey1_r[i] <= {py[CW-1], py} - {cy[i][CW-1], cy[i]};
    end
  end

  // Stage 2: square handle checks, then the flags ride to stage 6.
  logic signed [DW:0] rpos;
  logic [3:0]         handle_nxt;
  pick_flags_t        fl_r [2:6];

  assign rpos = $signed({{(DW+1-RADIUS_W){1'b0}}, radius_r});

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      handle_nxt[i] = ($signed({hex1_r[i][DW-1], hex1_r[i]}) >= -rpos) &&
                      ($signed({hex1_r[i][DW-1], hex1_r[i]}) <= rpos) &&
                      ($signed({hey1_r[i][DW-1], hey1_r[i]}) >= -rpos) &&
                      ($signed({hey1_r[i][DW-1], hey1_r[i]}) <= rpos);
    end
  end

  always_ff @(posedge clk) begin
    fl_r[2] <= '{box_a: box_a1_r, box_b: box_b1_r, handle: handle_nxt};
    for (int s = 3; s <= 6; s++) begin
      fl_r[s] <= fl_r[s-1];
    end
  end

  // Segment units: left, top, right, bottom and the bl-tr diagonal.
  logic [4:0] seg_hit;

  qohc_seg #(.COORD_BITS(COORD_BITS), .TOLERANCE_RECIPROCAL(TOLERANCE_RECIPROCAL)) u_seg_left (
    .clk(clk), .ax(cx[C_BL]), .ay(cy[C_BL]), .bx(cx[C_TL]), .by(cy[C_TL]),
    .px(px), .py(py), .hit(seg_hit[SEG_LEFT])
  );

  qohc_seg #(.COORD_BITS(COORD_BITS), .TOLERANCE_RECIPROCAL(TOLERANCE_RECIPROCAL)) u_seg_top (
    .clk(clk), .ax(cx[C_TL]), .ay(cy[C_TL]), .bx(cx[C_TR]), .by(cy[C_TR]),
    .px(px), .py(py), .hit(seg_hit[SEG_TOP])
  );

  qohc_seg #(.COORD_BITS(COORD_BITS), .TOLERANCE_RECIPROCAL(TOLERANCE_RECIPROCAL)) u_seg_right (
    .clk(clk), .ax(cx[C_TR]), .ay(cy[C_TR]), .bx(cx[C_BR]), .by(cy[C_BR]),
    .px(px), .py(py), .hit(seg_hit[SEG_RIGHT])
  );

  qohc_seg #(.COORD_BITS(COORD_BITS), .TOLERANCE_RECIPROCAL(TOLERANCE_RECIPROCAL)) u_seg_bottom (
    .clk(clk), .ax(cx[C_BR]), .ay(cy[C_BR]), .bx(cx[C_BL]), .by(cy[C_BL]),
    .px(px), .py(py), .hit(seg_hit[SEG_BOTTOM])
  );

  qohc_seg #(.COORD_BITS(COORD_BITS), .TOLERANCE_RECIPROCAL(TOLERANCE_RECIPROCAL)) u_seg_diag (
    .clk(clk), .ax(cx[C_BL]), .ay(cy[C_BL]), .bx(cx[C_TR]), .by(cy[C_TR]),
    .px(px), .py(py), .hit(seg_hit[SEG_DIAG])
  );

  // Triangle units: bl-tl-tr and bl-tr-br.
  logic tri_a_hit, tri_b_hit;

  qohc_tri #(.COORD_BITS(COORD_BITS)) u_tri_a (
    .clk(clk), .ax(cx[C_BL]), .ay(cy[C_BL]), .bx(cx[C_TL]), .by(cy[C_TL]),
    .cx(cx[C_TR]), .cy(cy[C_TR]), .px(px), .py(py), .hit(tri_a_hit)
  );

  qohc_tri #(.COORD_BITS(COORD_BITS)) u_tri_b (
    .clk(clk), .ax(cx[C_BL]), .ay(cy[C_BL]), .bx(cx[C_TR]), .by(cy[C_TR]),
    .cx(cx[C_BR]), .cy(cy[C_BR]), .px(px), .py(py), .hit(tri_b_hit)
  );

  // Stage 6: priority selection of the hit code.
  logic [HIT_W-1:0] hit_nxt;

  always_comb begin
    hit_nxt = HIT_NONE;
    if (fl_r[6].box_a || fl_r[6].box_b) begin
      if (mode_r[MODE_VERTEX]) begin
        if (fl_r[6].handle[C_TL])      hit_nxt = HIT_TL;
        else if (fl_r[6].handle[C_TR]) hit_nxt = HIT_TR;
        else if (fl_r[6].handle[C_BR]) hit_nxt = HIT_BR;
        else if (fl_r[6].handle[C_BL]) hit_nxt = HIT_BL;
      end
      if ((hit_nxt == HIT_NONE) && mode_r[MODE_EDGE]) begin
        if (seg_hit[SEG_LEFT])        hit_nxt = HIT_LEFT;
        else if (seg_hit[SEG_TOP])    hit_nxt = HIT_TOP;
        else if (seg_hit[SEG_RIGHT])  hit_nxt = HIT_RIGHT;
        else if (seg_hit[SEG_BOTTOM]) hit_nxt = HIT_BOTTOM;
      end
      if ((hit_nxt == HIT_NONE) && !mode_r[MODE_VERTEX] && fl_r[6].box_a) begin
        hit_nxt = HIT_WHOLE;
      end
      if ((hit_nxt == HIT_NONE) && (tri_a_hit || tri_b_hit || seg_hit[SEG_DIAG])) begin
        hit_nxt = HIT_WHOLE;
      end
    end
  end

  // Stage 7: result register.
  logic             out_valid_r;
  logic [HIT_W-1:0] out_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v_r[6];
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r <= hit_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_hit_part = out_hit_r;

  // Helper terms for the checks below.
  logic out_is_handle;
  logic box_any6;

  assign out_is_handle = out_valid && ((out_hit_part == HIT_TL) || (out_hit_part == HIT_TR) ||
                                       (out_hit_part == HIT_BR) || (out_hit_part == HIT_BL));
  assign box_any6      = fl_r[6].box_a || fl_r[6].box_b;

  // Every accepted word produces exactly one strobe on out_valid.
  `QOHC_ASSERT_IMP(a_latency, clk, rst_n, accept, ##7 out_valid, "result strobe missing")
  `QOHC_ASSERT_IMP(a_no_phantom, clk, rst_n, out_valid, $past(accept, 7), "result without a word")
  // Handle codes appear only with vertex mode on.
  `QOHC_ASSERT_IMP(a_handle_mode, clk, rst_n, out_is_handle, $past(mode_r[MODE_VERTEX]), "handle hit with vertex mode off")
  // Any hit requires the point to lie in one of the bounding boxes.
  `QOHC_ASSERT_IMP(a_box_gate, clk, rst_n, out_valid && (out_hit_part != HIT_NONE), $past(box_any6), "hit outside both boxes")

endmodule
